@@ rtl/core/ctd_pkg.sv @@
// Shared types and constants for the capacitive touch detector.
`default_nettype none

package ctd_pkg;

    localparam int unsigned LVL_W     = 13;  // charge level, baseline, threshold
    localparam int unsigned SUM_W     = 20;  // calibration accumulator
    localparam int unsigned CNT_W     = 7;   // calibration sample counter
    localparam int unsigned RUN_W     = 4;   // debounce run counters
    localparam int unsigned DRIFT_W   = 4;   // drift shift register
    localparam int unsigned CFG_IDX_W = 2;

    // Tracking accumulator holds baseline << 15 plus a level.
    localparam int unsigned TRK_W = LVL_W + (2 ** DRIFT_W);

    localparam logic [RUN_W-1:0] RUN_MAX = '1;

    // Threshold is baseline / 12, done as (baseline >> 2) * 2731 >> 13.
    localparam int unsigned THR_DIV      = 12;
    localparam int unsigned DIV3_MUL_W   = 12;
    localparam int unsigned DIV3_MUL     = 2731;
    localparam int unsigned DIV3_SHIFT   = 13;

    localparam logic [LVL_W-1:0]   RST_THRESHOLD_FLOOR = 13'd120;
    localparam logic [RUN_W-1:0]   RST_PRESS_COUNT     = 4'd2;
    localparam logic [RUN_W-1:0]   RST_RELEASE_COUNT   = 4'd3;
    localparam logic [DRIFT_W-1:0] RST_DRIFT_SHIFT     = 4'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD_FLOOR = 2'd0,
        CFG_PRESS_COUNT     = 2'd1,
        CFG_RELEASE_COUNT   = 2'd2,
        CFG_DRIFT_SHIFT     = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [LVL_W-1:0]   threshold_floor;
        logic [RUN_W-1:0]   press_count;
        logic [RUN_W-1:0]   release_count;
        logic [DRIFT_W-1:0] drift_shift;
    } t_cfg;

    typedef struct packed {
        logic             is_pressed;
        logic             taken_event;
        logic             is_calibrated;
        logic             below_level;
        logic [LVL_W-1:0] baseline_out;
        logic [LVL_W-1:0] threshold_out;
        logic [LVL_W-1:0] last_level;
    } t_result;

    typedef struct packed {
        logic             pressed;
        logic             event_flag;
        logic             calibrated;
        logic [RUN_W-1:0] low_run;
        logic [RUN_W-1:0] high_run;
    } t_status;

endpackage

`default_nettype wire

@@ rtl/core/ctd_cal_div.sv @@
// Calibration average and its threshold by constant reciprocal multiplication.
`default_nettype none

module ctd_cal_div #(
    parameter int unsigned CAL_SAMPLES = 24
) (
    input  logic [ctd_pkg::SUM_W-1:0] i_sum,
    output logic [ctd_pkg::LVL_W-1:0] o_baseline,
    output logic [ctd_pkg::LVL_W-1:0] o_thr_raw
);
    import ctd_pkg::*;

    localparam int unsigned MUL_W  = SUM_W + 1;
    localparam int unsigned PROD_W = SUM_W + MUL_W;

    // floor(x / d) = (x * ceil(2^(N+L) / d)) >> (N+L) for every x below 2^N,
    // with L = clog2(d). The threshold divides the sum by 12 * d directly.
    localparam int unsigned AvgDiv = CAL_SAMPLES;
    localparam int unsigned ThrDiv = CAL_SAMPLES * THR_DIV;
    localparam int unsigned AvgL   = $clog2(AvgDiv);
    localparam int unsigned ThrL   = $clog2(ThrDiv);
    localparam logic [63:0] AvgMul =
        ((64'd1 << (SUM_W + AvgL)) + 64'(AvgDiv) - 64'd1) / 64'(AvgDiv);
    localparam logic [63:0] ThrMul =
        ((64'd1 << (SUM_W + ThrL)) + 64'(ThrDiv) - 64'd1) / 64'(ThrDiv);

    logic [PROD_W-1:0] avg_prod;
    logic [PROD_W-1:0] thr_prod;
    logic [PROD_W-1:0] avg_quo;
    logic [PROD_W-1:0] thr_quo;

    assign avg_prod = PROD_W'(i_sum) * PROD_W'(AvgMul[MUL_W-1:0]);
    assign thr_prod = PROD_W'(i_sum) * PROD_W'(ThrMul[MUL_W-1:0]);
    assign avg_quo  = avg_prod >> (SUM_W + AvgL);
    assign thr_quo  = thr_prod >> (SUM_W + ThrL);

    assign o_baseline = avg_quo[LVL_W-1:0];
    assign o_thr_raw  = thr_quo[LVL_W-1:0];

endmodule

`default_nettype wire

@@ rtl/core/ctd_track.sv @@
// Baseline drift tracking filter and the threshold derived from the new baseline.
`default_nettype none

module ctd_track (
    input  logic [ctd_pkg::LVL_W-1:0]   i_baseline,
    input  logic [ctd_pkg::LVL_W-1:0]   i_level,
    input  logic [ctd_pkg::DRIFT_W-1:0] i_shift,
    output logic [ctd_pkg::LVL_W-1:0]   o_baseline,
    output logic [ctd_pkg::LVL_W-1:0]   o_thr_raw
);
    import ctd_pkg::*;

    localparam int unsigned Q_W    = LVL_W - 2;
    localparam int unsigned PROD_W = Q_W + DIV3_MUL_W;

    logic [TRK_W-1:0]  base_wide;
    logic [TRK_W-1:0]  acc;
    logic [TRK_W-1:0]  filtered;
    logic [LVL_W-1:0]  base_new;
    logic [PROD_W-1:0] div_prod;

    // baseline * (2^s - 1) + level, written as a shift and a subtract.
    assign base_wide = TRK_W'(i_baseline);
    assign acc       = (base_wide << i_shift) - base_wide + TRK_W'(i_level);
    assign filtered  = acc >> i_shift;
    assign base_new  = filtered[LVL_W-1:0];

    assign div_prod  = PROD_W'(base_new[LVL_W-1:2]) * PROD_W'(DIV3_MUL);

    assign o_baseline = base_new;
    assign o_thr_raw  = LVL_W'(div_prod[PROD_W-1:DIV3_SHIFT]);

endmodule

`default_nettype wire

@@ rtl/core/ctd_state.sv @@
// Detector state registers with calibration, tracking and debounce update.
`default_nettype none

module ctd_state #(
    parameter int unsigned CAL_SAMPLES = 24
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  logic                      i_req_type,
    input  logic [ctd_pkg::LVL_W-1:0] i_level,
    input  ctd_pkg::t_cfg             i_cfg,
    output ctd_pkg::t_result          o_result,
    output ctd_pkg::t_status          o_status
);
    import ctd_pkg::*;

    localparam logic [CNT_W-1:0] CalCount = CNT_W'(CAL_SAMPLES);

    logic [CNT_W-1:0] r_cal_cnt, n_cal_cnt;
    logic [SUM_W-1:0] r_cal_sum, n_cal_sum;
    logic [LVL_W-1:0] r_baseline, n_baseline;
    logic [LVL_W-1:0] r_threshold, n_threshold;
    logic [LVL_W-1:0] r_recent, n_recent;
    logic [RUN_W-1:0] r_low_run, n_low_run;
    logic [RUN_W-1:0] r_high_run, n_high_run;
    logic             r_pressed, n_pressed;
    logic             r_event, n_event;

    logic [SUM_W-1:0] sum_inc;
    logic [LVL_W-1:0] cal_baseline;
    logic [LVL_W-1:0] cal_thr_raw;
    logic [LVL_W-1:0] trk_baseline;
    logic [LVL_W-1:0] trk_thr_raw;
    logic             below;
    logic             taken;

    function automatic logic [LVL_W-1:0] floor_max(input logic [LVL_W-1:0] raw,
                                                   input logic [LVL_W-1:0] floor_val);
        return (raw < floor_val) ? floor_val : raw;
    endfunction

    assign sum_inc = r_cal_sum + SUM_W'(i_level);

    ctd_cal_div #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_cal_div (
        .i_sum      (sum_inc),
        .o_baseline (cal_baseline),
        .o_thr_raw  (cal_thr_raw)
    );

    ctd_track u_track (
        .i_baseline (r_baseline),
        .i_level    (i_level),
        .i_shift    (i_cfg.drift_shift),
        .o_baseline (trk_baseline),
        .o_thr_raw  (trk_thr_raw)
    );

    always_comb begin
        n_cal_cnt   = r_cal_cnt;
        n_cal_sum   = r_cal_sum;
        n_baseline  = r_baseline;
        n_threshold = r_threshold;
        n_recent    = r_recent;
        n_low_run   = r_low_run;
        n_high_run  = r_high_run;
        n_pressed   = r_pressed;
        n_event     = r_event;
        taken       = 1'b0;
        below       = 1'b0;

        if (i_req_type) begin
            taken   = r_event;
            n_event = 1'b0;
        end else if (r_cal_cnt < CalCount) begin
            n_cal_sum = sum_inc;
            n_cal_cnt = r_cal_cnt + 1'b1;
            if (n_cal_cnt >= CalCount) begin
                n_baseline  = cal_baseline;
                n_threshold = floor_max(cal_thr_raw, i_cfg.threshold_floor);
                n_recent    = cal_baseline;
            end
        end else begin
            n_recent = i_level;
            below = ({1'b0, i_level} + {1'b0, r_threshold}) < {1'b0, r_baseline};

            // The baseline only follows the sensor while nothing touches it.
            if (!r_pressed && !below) begin
                n_baseline  = trk_baseline;
                n_threshold = floor_max(trk_thr_raw, i_cfg.threshold_floor);
            end

            if (below) begin
                n_low_run  = (r_low_run == RUN_MAX) ? r_low_run : r_low_run + 1'b1;
                n_high_run = '0;
                if (!r_pressed && n_low_run >= i_cfg.press_count) begin
                    n_pressed = 1'b1;
                    n_event   = 1'b1;
                end
            end else begin
                n_high_run = (r_high_run == RUN_MAX) ? r_high_run : r_high_run + 1'b1;
                n_low_run  = '0;
                if (r_pressed && n_high_run >= i_cfg.release_count) begin
                    n_pressed = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_cnt   <= '0;
            r_cal_sum   <= '0;
            r_baseline  <= '0;
            r_threshold <= '0;
            r_recent    <= '0;
            r_low_run   <= '0;
            r_high_run  <= '0;
            r_pressed   <= 1'b0;
            r_event     <= 1'b0;
        end else if (i_step) begin
            r_cal_cnt   <= n_cal_cnt;
            r_cal_sum   <= n_cal_sum;
            r_baseline  <= n_baseline;
            r_threshold <= n_threshold;
            r_recent    <= n_recent;
            r_low_run   <= n_low_run;
            r_high_run  <= n_high_run;
            r_pressed   <= n_pressed;
            r_event     <= n_event;
        end
    end

    assign o_result.is_pressed    = n_pressed;
    assign o_result.taken_event   = taken;
    assign o_result.is_calibrated = (n_cal_cnt >= CalCount);
    assign o_result.below_level   = below;
    assign o_result.baseline_out  = n_baseline;
    assign o_result.threshold_out = n_threshold;
    assign o_result.last_level    = n_recent;

    assign o_status.pressed    = r_pressed;
    assign o_status.event_flag = r_event;
    assign o_status.calibrated = (r_cal_cnt >= CalCount);
    assign o_status.low_run    = r_low_run;
    assign o_status.high_run   = r_high_run;

endmodule

`default_nettype wire

@@ rtl/core/capacitive_touch_detector.sv @@
// Path: an accepted item is held in the input register, then its result is written to the
// result register and shown on the master side.
// Throughput: one item per cycle unless the result register is held; the state update for an
// item is one pass of logic between the input register and the result register.
// Reset: synchronous, active low; clears the detector state and the handshakes and
// loads the configuration registers with their default values.
`default_nettype none

module capacitive_touch_detector #(
    parameter int unsigned CAL_SAMPLES = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input item stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [15:0]                   i_s_tdata,  // [12:0] sample_level
    input  logic                          i_s_tuser,  // [0] req_type
    // Result item stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [0] is_pressed, [1] taken_event, [2] is_calibrated, [3] below_level,
    // [16:4] baseline_out, [29:17] threshold_out, [42:30] last_level
    output logic [47:0]                   o_m_tdata,
    // Configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ctd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ctd_pkg::LVL_W-1:0]     i_cfg_data
);
    import ctd_pkg::*;

    logic             r_in_valid;
    logic             r_in_req;
    logic [LVL_W-1:0] r_in_level;
    logic             r_out_valid;
    t_result          r_out;
    t_cfg             r_cfg;

    logic    w_advance;
    t_result w_result;
    t_status st;

    // The input register moves on whenever the result register is free or drains.
    assign w_advance  = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold_floor <= RST_THRESHOLD_FLOOR;
            r_cfg.press_count     <= RST_PRESS_COUNT;
            r_cfg.release_count   <= RST_RELEASE_COUNT;
            r_cfg.drift_shift     <= RST_DRIFT_SHIFT;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_THRESHOLD_FLOOR: r_cfg.threshold_floor <= i_cfg_data;
                CFG_PRESS_COUNT:     r_cfg.press_count     <= i_cfg_data[RUN_W-1:0];
                CFG_RELEASE_COUNT:   r_cfg.release_count   <= i_cfg_data[RUN_W-1:0];
                CFG_DRIFT_SHIFT:     r_cfg.drift_shift     <= i_cfg_data[DRIFT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_req   <= i_s_tuser;
            r_in_level <= i_s_tdata[LVL_W-1:0];
        end
    end

    ctd_state #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_advance),
        .i_req_type (r_in_req),
        .i_level    (r_in_level),
        .i_cfg      (r_cfg),
        .o_result   (w_result),
        .o_status   (st)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0, r_out.last_level, r_out.threshold_out, r_out.baseline_out,
                         r_out.below_level, r_out.is_calibrated, r_out.taken_event,
                         r_out.is_pressed};

    // A sample always clears one of the two run counters.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st.low_run == '0 || st.high_run == '0)
        else $error("both debounce run counters are nonzero");

    // A press can only be declared against a formed baseline.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st.pressed |-> st.calibrated)
        else $error("pressed state set before calibration finished");

    // A take request leaves the press event cleared.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && r_in_req |=> !st.event_flag)
        else $error("press event still latched after a take request");

endmodule

`default_nettype wire
